[design/serial_frame_receive_checker_top_assert.svh]
// Assertion macros shared by the receive checker RTL.
// Each macro takes a label, an antecedent and a consequent, and is clocked on aclk
// with aresetn as the disable condition.
`ifndef SERIAL_FRAME_RECEIVE_CHECKER_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVE_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SFRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfrc assertion failed");

`define SFRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfrc assertion failed");

`else

`define SFRC_ASSERT_SAME(label, ante, cons)

`define SFRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/sfrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

    localparam int unsigned ByteW = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

    localparam logic [ByteW-1:0] START_MARKER_RST = 8'd253;
    localparam logic [ByteW-1:0] END_MARKER_RST   = 8'h0d;
    localparam logic [ByteW-1:0] MAX_LENGTH_RST   = 8'd40;

    // Event codes reported with each word.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_GOOD    = 2'd1;
    localparam logic [1:0] EV_BAD_SUM = 2'd2;
    localparam logic [1:0] EV_BAD_LEN = 2'd3;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_DIR     = 8'b0000_0010,
        PH_CMD     = 8'b0000_0100,
        PH_LEN     = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CHECK   = 8'b0010_0000,
        PH_END     = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } sfrc_phase_t;

    typedef struct packed {
        logic [ByteW-1:0] start_marker;
        logic [ByteW-1:0] end_marker;
        logic [ByteW-1:0] max_length;
    } sfrc_cfg_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [ByteW-1:0] frame_cmd;
        logic [ByteW-1:0] frame_length;
        logic [ByteW-1:0] payload_byte;
        logic             payload_valid;
    } sfrc_result_t;

endpackage

`default_nettype wire

[design/sfrc_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfrc_parser (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic [sfrc_pkg::ByteW-1:0] rx_byte,
    input  wire logic                      idle_event,
    input  wire sfrc_pkg::sfrc_cfg_t       cfg,
    output sfrc_pkg::sfrc_result_t         result
);
    import sfrc_pkg::*;

    sfrc_phase_t      phase_reg, phase_next;
    logic [ByteW-1:0] count_reg, count_next;
    logic [ByteW-1:0] length_reg, length_next;
    logic [ByteW-1:0] cmd_reg, cmd_next;
    logic [ByteW-1:0] sum_reg, sum_next;
    logic [1:0]       event_res;
    logic             payload_valid;
    logic             last_payload;

    // The last payload byte is the one that brings the count up to length minus one.
    assign last_payload = ({1'b0, count_reg} + 9'd2) >= {1'b0, length_reg};

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        event_res     = EV_NONE;
        payload_valid = 1'b0;
        if (idle_event) begin
            phase_next  = PH_HUNT;
            count_next  = '0;
            length_next = '0;
            cmd_next    = '0;
            sum_next    = '0;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == cfg.start_marker) begin
                        phase_next = PH_DIR;
                    end
                end
                PH_DIR: begin
                    phase_next = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    length_next = rx_byte;
                    count_next  = '0;
                    sum_next    = '0;
                    if (rx_byte == '0 || rx_byte > cfg.max_length) begin
                        event_res  = EV_BAD_LEN;
                        phase_next = PH_DONE;
                    end else if (rx_byte == ByteW'(1)) begin
                        phase_next = PH_CHECK;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    payload_valid = 1'b1;
                    sum_next      = sum_reg + rx_byte;
                    count_next    = count_reg + ByteW'(1);
                    if (last_payload) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    // A matching checksum leaves the running sum at zero.
                    sum_next   = sum_reg - rx_byte;
                    phase_next = PH_END;
                end
                PH_END: begin
                    event_res  = (sum_reg == '0 && rx_byte == cfg.end_marker) ?
                                 EV_GOOD : EV_BAD_SUM;
                    phase_next = PH_DONE;
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            length_reg <= '0;
            cmd_reg    <= '0;
            sum_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            cmd_reg    <= cmd_next;
            sum_reg    <= sum_next;
        end
    end

    assign result.event_res     = event_res;
    assign result.frame_cmd     = cmd_next;
    assign result.frame_length  = length_next;
    assign result.payload_byte  = payload_valid ? rx_byte : '0;
    assign result.payload_valid = payload_valid;

endmodule

`default_nettype wire

[design/serial_frame_receive_checker_top.sv]
// A result word is registered and appears on the m_ side in the cycle after its input word is accepted.
// Throughput: one word per cycle; a new word is taken while the held result drains.
// The single output register stalls input only while its word waits for m_ready.
// Reset (aresetn, synchronous, active low) returns the parser to hunting for the start
// marker, clears the frame state and loads the default marker and length registers.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receive_checker_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [sfrc_pkg::ByteW-1:0] cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [sfrc_pkg::ByteW-1:0] s_rx_byte,
    input  wire logic                       s_idle_event,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_event_res,
    output logic [sfrc_pkg::ByteW-1:0]      m_frame_cmd,
    output logic [sfrc_pkg::ByteW-1:0]      m_frame_length,
    output logic [sfrc_pkg::ByteW-1:0]      m_payload_byte,
    output logic                            m_payload_valid
);
    import sfrc_pkg::*;

    `include "serial_frame_receive_checker_top_assert.svh"

    sfrc_cfg_t    cfg_reg;
    sfrc_result_t result;
    sfrc_result_t res_reg;
    logic         m_valid_reg;
    logic         in_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= START_MARKER_RST;
            cfg_reg.end_marker   <= END_MARKER_RST;
            cfg_reg.max_length   <= MAX_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_MARKER: cfg_reg.start_marker <= cfg_wdata;
                CFG_END_MARKER:   cfg_reg.end_marker   <= cfg_wdata;
                CFG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    sfrc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (in_accept),
        .rx_byte    (s_rx_byte),
        .idle_event (s_idle_event),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = res_reg.event_res;
    assign m_frame_cmd     = res_reg.frame_cmd;
    assign m_frame_length  = res_reg.frame_length;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_payload_valid = res_reg.payload_valid;

    `SFRC_ASSERT_NEXT(a_accept_gives_word, in_accept, m_valid_reg)
    `SFRC_ASSERT_NEXT(a_idle_clears_frame, in_accept && s_idle_event,
        res_reg.event_res == EV_NONE && res_reg.frame_cmd == '0 && res_reg.frame_length == '0)
    `SFRC_ASSERT_SAME(a_payload_no_event, m_valid_reg && res_reg.payload_valid,
        res_reg.event_res == EV_NONE)
    `SFRC_ASSERT_SAME(a_no_payload_zero, m_valid_reg && !res_reg.payload_valid,
        res_reg.payload_byte == '0)

endmodule

`default_nettype wire

[sim/serial_frame_receive_checker_top_tb.sv]
`timescale 1ns / 1ps

module serial_frame_receive_checker_top_tb;
    import sfrc_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 100;

    // The register port decodes two index bits, but only three registers exist.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef logic [ByteW-1:0] byte_t;
    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CADENCE} ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    byte_t       cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    byte_t       s_rx_byte;
    logic        s_idle_event;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_res;
    byte_t       m_frame_cmd;
    byte_t       m_frame_length;
    byte_t       m_payload_byte;
    logic        m_payload_valid;

    // Register copies and parser state of the prediction.
    byte_t       cfg_start;
    byte_t       cfg_end;
    byte_t       cfg_max;
    sfrc_phase_t parse_phase;
    byte_t       payload_count;
    byte_t       frame_len;
    byte_t       frame_cmd;
    byte_t       payload_sum;

    sfrc_result_t due_results[$];
    int unsigned  words_accepted = 0;
    int unsigned  burst_left = 0;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    ready_mode_t  ready_mode = RDY_ALWAYS;
    int unsigned  ready_hold = 0;

    serial_frame_receive_checker_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_idle_event    (s_idle_event),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_frame_cmd     (m_frame_cmd),
        .m_frame_length  (m_frame_length),
        .m_payload_byte  (m_payload_byte),
        .m_payload_valid (m_payload_valid)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_frame_receive_checker_top: mismatch");
            $finish;
        end
    end

    // The receiver switches between several stall patterns, each held for a while.
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(20, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:  m_ready <= 1'b1;
            RDY_COIN:    m_ready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= (cycle_count % 3 != 0);
        endcase
    end

    task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input byte_t got, input byte_t want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin : check_result_port
        sfrc_result_t got;
        sfrc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.event_res     = m_event_res;
            got.frame_cmd     = m_frame_cmd;
            got.frame_length  = m_frame_length;
            got.payload_byte  = m_payload_byte;
            got.payload_valid = m_payload_valid;
            if (due_results.size() == 0) begin
                report_mismatch("word with none expected", byte_t'(got.event_res), 8'h00);
            end else begin
                want = due_results.pop_front();
                check_field("event_res", byte_t'(got.event_res), byte_t'(want.event_res));
                check_field("frame_cmd", got.frame_cmd, want.frame_cmd);
                check_field("frame_length", got.frame_length, want.frame_length);
                check_field("payload_byte", got.payload_byte, want.payload_byte);
                check_field("payload_valid", byte_t'(got.payload_valid),
                            byte_t'(want.payload_valid));
            end
        end
    end

    task automatic clear_frame();
        parse_phase   = PH_HUNT;
        payload_count = '0;
        frame_len     = '0;
        frame_cmd     = '0;
        payload_sum   = '0;
    endtask

    function automatic sfrc_result_t parse_rx_word(input byte_t rx, input logic idle_ev);
        sfrc_result_t res;
        res = '0;
        res.event_res = EV_NONE;
        if (idle_ev) begin
            parse_phase   = PH_HUNT;
            payload_count = '0;
            frame_len     = '0;
            frame_cmd     = '0;
            payload_sum   = '0;
        end else begin
            case (parse_phase)
                PH_HUNT: begin
                    if (rx == cfg_start)
                        parse_phase = PH_DIR;
                end
                PH_DIR: parse_phase = PH_CMD;
                PH_CMD: begin
                    frame_cmd   = rx;
                    parse_phase = PH_LEN;
                end
                PH_LEN: begin
                    frame_len     = rx;
                    payload_count = '0;
                    payload_sum   = '0;
                    if (rx == 0 || rx > cfg_max) begin
                        res.event_res = EV_BAD_LEN;
                        parse_phase   = PH_DONE;
                    end else if (rx == 1) begin
                        parse_phase = PH_CHECK;
                    end else begin
                        parse_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx;
                    payload_sum       = payload_sum + rx;
                    payload_count     = payload_count + byte_t'(1);
                    if ({1'b0, payload_count} + 9'd1 >= {1'b0, frame_len})
                        parse_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    // Subtracting the checksum leaves zero when it matches.
                    payload_sum = payload_sum - rx;
                    parse_phase = PH_END;
                end
                PH_END: begin
                    res.event_res = (payload_sum == 0 && rx == cfg_end) ? EV_GOOD : EV_BAD_SUM;
                    parse_phase   = PH_DONE;
                end
                default: ;
            endcase
        end
        res.frame_cmd    = frame_cmd;
        res.frame_length = frame_len;
        return res;
    endfunction

    task automatic send_word(input byte_t rx, input logic idle_ev);
        s_valid      <= 1'b1;
        s_rx_byte    <= rx;
        s_idle_event <= idle_ev;
        do @(posedge aclk); while (!s_ready);
        due_results.push_back(parse_rx_word(rx, idle_ev));
        words_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            // Now and then a long burst gives a stretch with no gaps at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 20);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input byte_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_START_MARKER: cfg_start = value;
            CFG_END_MARKER:   cfg_end   = value;
            CFG_MAX_LENGTH:   cfg_max   = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input byte_t start_mk, input byte_t end_mk, input byte_t max_len);
        drain_results();
        write_reg(CFG_START_MARKER, start_mk);
        write_reg(CFG_END_MARKER, end_mk);
        write_reg(CFG_MAX_LENGTH, max_len);
    endtask

    // Mostly well-formed frames with random content; the rest carry a wrong checksum,
    // a wrong end marker, a bad length, a cut at a random point, or plain line noise.
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        byte_t       sum;
        byte_t       rx;
        byte_t       bytes[$];
        pick = $urandom_range(0, 99);
        if (pick >= 96) begin
            repeat ($urandom_range(1, 4)) send_word(byte_t'($urandom), 1'b0);
            send_word(byte_t'($urandom), 1'b1);
            return;
        end
        if (cfg_max == 0)
            len = $urandom_range(0, 255);
        else if (pick >= 83 && pick < 91)
            len = (cfg_max == 8'hFF || $urandom_range(0, 1) == 0) ? 0
                                                                : $urandom_range(cfg_max + 1, 255);
        else if ($urandom_range(0, 9) != 0)
            len = $urandom_range(1, (cfg_max < 6) ? cfg_max : 6);
        else
            len = $urandom_range(1, cfg_max);
        bytes.push_back(cfg_start);
        bytes.push_back(byte_t'($urandom));
        bytes.push_back(byte_t'($urandom));
        bytes.push_back(byte_t'(len));
        if (len == 0 || len > cfg_max) begin
            // Everything after a bad length is ignored, so keep the tail short.
            repeat ($urandom_range(0, 2)) bytes.push_back(byte_t'($urandom));
        end else begin
            sum = '0;
            for (i = 1; i < len; i++) begin
                rx  = byte_t'($urandom);
                sum = sum + rx;
                bytes.push_back(rx);
            end
            if (pick >= 65 && pick < 75)
                bytes.push_back(sum + byte_t'($urandom_range(1, 255)));
            else
                bytes.push_back(sum);
            if (pick >= 75 && pick < 83)
                bytes.push_back(cfg_end ^ byte_t'($urandom_range(1, 255)));
            else
                bytes.push_back(cfg_end);
            if (pick >= 91) begin
                cut = $urandom_range(1, bytes.size() - 1);
                while (bytes.size() > cut) void'(bytes.pop_back());
            end else if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) bytes.push_back(byte_t'($urandom));
            end
        end
        foreach (bytes[k]) send_word(bytes[k], 1'b0);
        send_word(byte_t'($urandom), 1'b1);
    endtask

    task automatic run_random_frames(input int unsigned word_budget);
        int unsigned target;
        target = words_accepted + word_budget;
        while (words_accepted < target) begin
            send_random_frame();
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end
    endtask

    task automatic test_directed_cases();
        send_word(8'hFF, 1'b1);
        // Good frame with two payload bytes whose sum wraps to zero.
        send_word(START_MARKER_RST, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h03, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(END_MARKER_RST, 1'b0);
        // A byte after a judged frame is ignored until the line goes idle.
        send_word(START_MARKER_RST, 1'b0);
        send_word(8'h00, 1'b1);
        // Length zero.
        send_word(START_MARKER_RST, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'h7E, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        // Length one above the largest allowed.
        send_word(START_MARKER_RST, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'h81, 1'b0);
        send_word(MAX_LENGTH_RST + 8'd1, 1'b0);
        send_word(8'h00, 1'b1);
        // Length one: no payload, and the checksum must be zero.
        send_word(START_MARKER_RST, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(END_MARKER_RST, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_random_default_config();
        run_random_frames(250);
    endtask

    task automatic test_config_extremes();
        apply_config(8'h00, 8'hFF, 8'hFF);
        run_random_frames(110);
        apply_config(8'hFF, 8'h00, 8'h01);
        run_random_frames(110);
        // With a largest length of zero every frame has a bad length.
        apply_config(8'h7E, END_MARKER_RST, 8'h00);
        run_random_frames(110);
        apply_config(8'hA5, 8'h5A, 8'h10);
        run_random_frames(110);
        apply_config(START_MARKER_RST, END_MARKER_RST, MAX_LENGTH_RST);
        run_random_frames(60);
    endtask

    task automatic test_unused_register_index();
        drain_results();
        write_reg(CFG_UNUSED, byte_t'($urandom));
        run_random_frames(60);
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_START_MARKER;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_rx_byte    <= '0;
        s_idle_event <= 1'b0;
        m_ready      <= 1'b0;
        cfg_start = START_MARKER_RST;
        cfg_end   = END_MARKER_RST;
        cfg_max   = MAX_LENGTH_RST;
        clear_frame();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_default_config();
        test_config_extremes();
        test_unused_register_index();

        drain_results();
        if (error_count == 0) begin
            $display("serial_frame_receive_checker_top: match");
        end else begin
            $display("serial_frame_receive_checker_top: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/sfrc_pkg.sv
design/sfrc_parser.sv
design/serial_frame_receive_checker_top.sv
sim/serial_frame_receive_checker_top_tb.sv
